FILE: rtl/core/audio_ring_playout_with_volume_unit_defines.svh
// Assertion macros for the audio ring playout unit.
// Used by the checker; expects clk and rst in the scope of use.
`ifndef AUDIO_RING_PLAYOUT_WITH_VOLUME_UNIT_DEFINES_SVH
`define AUDIO_RING_PLAYOUT_WITH_VOLUME_UNIT_DEFINES_SVH

// property checked outside reset
`define ARPV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define ARPV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/arpv_pkg.sv
// Shared constants, types and codes of the audio ring playout unit.
// No dependencies.
`default_nettype none
package arpv_pkg;

  localparam int RING_AW        = 10;
  localparam int RING_DEPTH     = 1 << RING_AW;
  localparam int PACKET_SAMPLES = 32;
  localparam int PACKETS_MARGIN = 4;
  localparam int FILL_LOW       = PACKETS_MARGIN * PACKET_SAMPLES;
  localparam int FILL_HIGH      = RING_DEPTH - FILL_LOW;

  localparam int SAMPLE_W    = 16;
  localparam int ADC_W       = 12;
  localparam int DAC_W       = 10;
  localparam int METER_W     = 3;
  localparam int GAIN_W      = 24;
  localparam int SUM_W       = 32;
  localparam int VOL_W       = 16;
  localparam int TICK_W      = 10;
  localparam int METER_SHIFT = 20;
  localparam int CFG_IDX_W   = 2;

  localparam logic [VOL_W-1:0]    VOL_SILENT = 16'h8000;
  localparam logic [VOL_W-1:0]    VOL_RESET  = 16'd256;
  localparam logic [SAMPLE_W-1:0] CODE_BIAS  = 16'h8000;
  localparam logic [DAC_W-1:0]    DAC_MID    = 10'h200;
  localparam logic [METER_W-1:0]  METER_MAX  = 3'd7;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd2;

  typedef logic [RING_AW-1:0] ring_idx_t;

  // what the read stage hands to the scale stage for one tick
  typedef struct packed {
    logic              play;
    logic              mute;
    logic              entry_ok;
    logic              upd;
    logic [GAIN_W-1:0] new_gain;
  } tick_info_t;

endpackage
`default_nettype wire

FILE: rtl/core/arpv_if.sv
// Channel interfaces: input items, result items, configuration writes.
// Depends on arpv_pkg.
`default_nettype none
interface arpv_in_if;
  import arpv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [ADC_W-1:0]           adc_result;
  modport source (output valid, func, sample, adc_result, input ready);
  modport sink   (input valid, func, sample, adc_result, output ready);
endinterface

interface arpv_out_if;
  import arpv_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAC_W-1:0]   dac_code;
  logic               level_valid;
  logic [METER_W-1:0] level_meter;
  modport source (output valid, dac_code, level_valid, level_meter, input ready);
  modport sink   (input valid, dac_code, level_valid, level_meter, output ready);
endinterface

interface arpv_cfg_if;
  import arpv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VOL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/audio_ring_playout_with_volume_unit.sv
// Top level of the audio ring playout unit with volume and level meter.
// Depends on arpv_pkg, arpv_if, arpv_ram, arpv_front, arpv_back.
//
//   channel   dir   payload                                   request moves
//   items     in    func, sample, adc_result                  one sample write or one tick
//   results   out   dac_code, level_valid, level_meter        one result per tick
//   cfg       in    index, data                               one register write
//
// One item per cycle while items.ready is high. A tick reads the ring into the
// registered RAM output and tick info; the multiply runs combinationally on them
// and the result register loads when it is empty or its result is being taken.
// Writes give no result. The results register holds under stall while the
// read stage keeps accepting until it is also occupied.
// Reset is synchronous; the ring needs no clearing pass, since entries are
// written in order and unwritten ones read as zero.
`default_nettype none
module audio_ring_playout_with_volume_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  arpv_in_if.sink    items,
  arpv_out_if.source results,
  arpv_cfg_if.sink   cfg
);
  import arpv_pkg::*;

  logic               running;
  logic               mute;
  logic [VOL_W-1:0]   volume;
  logic               s1_take;
  logic               s1_valid;
  tick_info_t         s1_info;
  logic               ram_we;
  ring_idx_t          ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic               ram_re;
  ring_idx_t          ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      mute    <= 1'b0;
      volume  <= VOL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_RUNNING: running <= cfg.data[0];
        CFG_MUTE:    mute    <= cfg.data[0];
        CFG_VOLUME:  volume  <= cfg.data;
        default: ;
      endcase
    end
  end

  arpv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arpv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .func       (items.func),
    .sample     (items.sample),
    .adc_result (items.adc_result),
    .item_ready (items.ready),
    .running    (running),
    .mute       (mute),
    .volume     (volume),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_info    (s1_info),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  arpv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_info     (s1_info),
    .rdata       (ram_rdata),
    .s1_take     (s1_take),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .dac_code    (results.dac_code),
    .level_valid (results.level_valid),
    .level_meter (results.level_meter)
  );

endmodule
`default_nettype wire

FILE: rtl/core/arpv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module arpv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/arpv_front.sv
// Read stage: ring indexes, fill check, tick counter, gain precompute, RAM access.
// Depends on arpv_pkg.
`default_nettype none
module arpv_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  input  wire logic                          func,
  input  wire logic [arpv_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [arpv_pkg::ADC_W-1:0]    adc_result,
  output logic                               item_ready,
  input  wire logic                          running,
  input  wire logic                          mute,
  input  wire logic [arpv_pkg::VOL_W-1:0]    volume,
  input  wire logic                          s1_take,
  output logic                               s1_valid,
  output arpv_pkg::tick_info_t               s1_info,
  output logic                               ram_we,
  output arpv_pkg::ring_idx_t                ram_waddr,
  output logic [arpv_pkg::SAMPLE_W-1:0]      ram_wdata,
  output logic                               ram_re,
  output arpv_pkg::ring_idx_t                ram_raddr
);
  import arpv_pkg::*;

  ring_idx_t         wi;
  ring_idx_t         ri;
  ring_idx_t         ri_next;
  ring_idx_t         fill;
  logic              wrapped;
  logic [TICK_W-1:0] tick_count;
  logic              en1;
  logic              acc;
  logic              wr;
  logic              tk;
  logic              skip_hi;
  logic              skip_lo;
  logic [5:0]        pot_base;
  logic [21:0]       vol_prod;
  logic [GAIN_W-1:0] new_gain;

  assign en1        = !s1_valid || s1_take;
  assign item_ready = en1 && !rst;
  assign acc        = item_valid && item_ready;
  assign wr         = acc && (func == FUNC_WRITE);
  assign tk         = acc && (func == FUNC_TICK);

  assign fill    = wi - ri;
  assign skip_hi = (fill == RING_AW'(FILL_HIGH));
  assign skip_lo = (fill > RING_AW'(FILL_LOW));
  assign ri_next = ri + RING_AW'(skip_hi) + RING_AW'(skip_lo);

  // pot = ((adc >> 4) & 0xF8) + ((adc >> 3) & 0x08), i.e. (adc[11:7] + adc[6]) << 3
  assign pot_base = {1'b0, adc_result[11:7]} + 6'(adc_result[6]);
  assign vol_prod = 22'(volume) * 22'(pot_base);
  assign new_gain = (volume == VOL_SILENT) ? '0 : GAIN_W'({vol_prod, 3'b000});

  assign ram_we    = wr;
  assign ram_waddr = wi;
  assign ram_wdata = sample;
  assign ram_re    = tk;
  assign ram_raddr = ri;

  always_ff @(posedge clk) begin
    if (rst) begin
      wi         <= '0;
      ri         <= '0;
      wrapped    <= 1'b0;
      tick_count <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (wr) begin
        wi <= wi + 1'b1;
        if (wi == '1) begin
          wrapped <= 1'b1;
        end
      end
      if (tk) begin
        tick_count <= tick_count + 1'b1;
        if (running) begin
          ri <= ri_next;
        end
      end
      if (en1) begin
        s1_valid <= tk;
      end
    end
  end

  // entries are filled in order from zero, so an unwritten entry still reads as zero
  always_ff @(posedge clk) begin
    if (tk) begin
      s1_info.play     <= running;
      s1_info.mute     <= mute;
      s1_info.entry_ok <= wrapped || (ri < wi);
      s1_info.upd      <= (tick_count == '0);
      s1_info.new_gain <= new_gain;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/arpv_back.sv
// Scale stage and output register: gain multiply, level sum, meter, gain reload.
// Depends on arpv_pkg.
`default_nettype none
module arpv_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s1_valid,
  input  wire arpv_pkg::tick_info_t          s1_info,
  input  wire logic [arpv_pkg::SAMPLE_W-1:0] rdata,
  output logic                               s1_take,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [arpv_pkg::DAC_W-1:0]         dac_code,
  output logic                               level_valid,
  output logic [arpv_pkg::METER_W-1:0]       level_meter
);
  import arpv_pkg::*;

  logic [GAIN_W-1:0]          gain;
  logic [SUM_W-1:0]           level_sum;
  logic [SUM_W-1:0]           sum_new;
  logic signed [SAMPLE_W-1:0] s;
  logic signed [SAMPLE_W:0]   sx;
  logic [SAMPLE_W:0]          mag;
  logic [SAMPLE_W:0]          add;
  logic signed [SAMPLE_W+GAIN_W:0] prod;
  logic [SUM_W-METER_SHIFT-1:0] m;
  logic [METER_W-1:0]         meter;
  logic                       en2;
  logic                       mv;
  logic [SAMPLE_W-1:0]        s2_p;
  logic [SAMPLE_W-1:0]        code;
  logic                       s2_mid;

  assign en2     = !out_valid || out_ready;
  assign s1_take = en2;
  assign mv      = s1_valid && en2;

  assign s   = s1_info.entry_ok ? rdata : '0;
  assign sx  = {s[SAMPLE_W-1], s};
  assign mag = sx[SAMPLE_W] ? (SAMPLE_W+1)'(-sx) : sx;
  assign add = s1_info.play ? mag : '0;
  assign sum_new = level_sum + SUM_W'(add);

  assign m     = sum_new[SUM_W-1:METER_SHIFT];
  assign meter = (m > (SUM_W-METER_SHIFT)'(METER_MAX)) ? METER_MAX : m[METER_W-1:0];

  assign prod = (SAMPLE_W+GAIN_W+1)'(s) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      gain      <= '0;
      level_sum <= '0;
    end else begin
      if (en2) begin
        out_valid <= s1_valid;
      end
      if (mv) begin
        if (s1_info.upd) begin
          gain      <= s1_info.new_gain;
          level_sum <= '0;
        end else begin
          level_sum <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      s2_p        <= prod[31:16];
      s2_mid      <= !s1_info.play || s1_info.mute;
      level_valid <= s1_info.upd;
      level_meter <= s1_info.upd ? meter : '0;
    end
  end

  assign code     = s2_p + CODE_BIAS;
  assign dac_code = s2_mid ? DAC_MID : code[SAMPLE_W-1:SAMPLE_W-DAC_W];

endmodule
`default_nettype wire

FILE: rtl/core/arpv_checker.sv
// Port-level checks for the audio ring playout unit, bound to the top level.
// Depends on arpv_pkg and the assertion macro header.
`default_nettype none
`include "audio_ring_playout_with_volume_unit_defines.svh"
module arpv_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_func,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [arpv_pkg::DAC_W-1:0]    dac_code,
  input wire logic                          level_valid,
  input wire logic [arpv_pkg::METER_W-1:0]  level_meter
);
  import arpv_pkg::*;

  // a stalled result keeps its payload
  `ARPV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(level_valid) && $stable(level_meter), "result changed under stall")

  `ARPV_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result pending after reset")

  // with the output register empty, a tick reaches the port via the tick info and result registers
  `ARPV_ASSERT(a_tick_latency, $rose(out_valid) |-> $past(in_valid && in_ready && (in_func == FUNC_TICK), 2), "result without a matching tick")

  `ARPV_ASSERT(a_meter_quiet, out_valid && !level_valid |-> level_meter == '0, "meter set off a reload tick")

endmodule

bind audio_ring_playout_with_volume_unit arpv_checker u_arpv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_func     (items.func),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .dac_code    (results.dac_code),
  .level_valid (results.level_valid),
  .level_meter (results.level_meter)
);
`default_nettype wire
